@@ hw/rtl/wrss_pkg.sv @@
// wrss_pkg: constants and register codes for the water ripple stencil step
// no dependencies; imported by water_ripple_stencil_step

package wrss_pkg;

    // cells in one row of the height map
    localparam int ROW_WIDTH = 160;

    localparam int COL_W     = $clog2(ROW_WIDTH);
    localparam int NADDR_W   = $clog2(2 * ROW_WIDTH);
    localparam int HEIGHT_W  = 16;
    localparam int COORD_W   = 10;
    localparam int SHIFT_W   = 4;
    localparam int ROWS_W    = 10;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hffff;
    localparam logic [SHIFT_W-1:0]  DAMPING_SHIFT_RESET = 4'd11;
    localparam logic [ROWS_W-1:0]   FRAME_ROWS_RESET    = 10'd85;
    localparam logic [ROWS_W-1:0]   FRAME_ROWS_MIN      = 10'd2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 1'd1;

endpackage

@@ hw/rtl/water_ripple_stencil_step.sv @@
// water_ripple_stencil_step: streaming ripple update over two raster height maps
// depends on wrss_pkg for widths, reset values and register codes

// One cell per transfer in raster order. Results trail the input by one row: a cell
// in row r yields the updated cell in row r-1, same column; row 0 yields nothing and
// the last row yields two results (cell above, then the current border cell). Away
// from the last row the block takes one item per clock unless the output is held
// back; on the last row two results share the single output register, so the input
// waits while the second is sent. The newer map lives in a two-bank line
// memory with two read ports (cell above and next cell of the previous row), the
// older map and force flag in a one-row delay memory; both are read and written in
// the cycle of the input transfer. No clearing pass is needed after reset.

module water_ripple_stencil_step
    import wrss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [HEIGHT_W-1:0]   newer_height,
    input  logic [HEIGHT_W-1:0]   older_height,
    input  logic                  force_peak,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [HEIGHT_W-1:0]   new_height,
    output logic [COORD_W-1:0]    cell_column,
    output logic [COORD_W-1:0]    cell_row,
    output logic                  frame_end,
    output logic                  last_of_run
);

    localparam logic [COL_W-1:0]   LAST_COL = COL_W'(ROW_WIDTH - 1);
    localparam logic [NADDR_W-1:0] BANK_OFS = NADDR_W'(ROW_WIDTH);

    // configuration
    logic [SHIFT_W-1:0] damping_shift_reg;
    logic [ROWS_W-1:0]  frame_rows_reg;

    // raster position
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROWS_W-1:0]  row_reg, row_next;

    // memories
    logic [HEIGHT_W-1:0] newer_mem [2*ROW_WIDTH];
    logic [HEIGHT_W:0]   older_mem [ROW_WIDTH];

    logic [HEIGHT_W-1:0] rd_above_reg;
    logic [HEIGHT_W-1:0] rd_right_reg;
    logic [HEIGHT_W:0]   rd_older_reg;

    // previous-row window, fed by the right-hand read of earlier items
    logic [HEIGHT_W-1:0] win_mid_reg;
    logic [HEIGHT_W-1:0] win_left_reg;

    // pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROWS_W-1:0]   s1_row_reg;
    logic [HEIGHT_W-1:0] s1_below_reg;
    logic                s1_last_row_reg;
    logic                s1_interior_reg;
    logic                s1_fend_reg;
    logic [HEIGHT_W:0]   s1_cur_reg;

    // stage 2
    logic [COL_W-1:0]    s2_col_reg;
    logic [ROWS_W-1:0]   s2_row_reg;
    logic [HEIGHT_W-1:0] s2_smooth_reg;
    logic [HEIGHT_W:0]   s2_held_reg;
    logic                s2_last_row_reg;
    logic                s2_interior_reg;
    logic                s2_fend_reg;
    logic [HEIGHT_W:0]   s2_cur_reg;

    // stage 3
    logic [COL_W-1:0]    s3_col_reg;
    logic [ROWS_W-1:0]   s3_row_reg;
    logic [HEIGHT_W-1:0] s3_diff_reg;
    logic [HEIGHT_W:0]   s3_held_reg;
    logic                s3_last_row_reg;
    logic                s3_interior_reg;
    logic                s3_fend_reg;
    logic [HEIGHT_W:0]   s3_cur_reg;

    // stage 4: up to two results waiting for the output register
    logic [COL_W-1:0]    s4_col_reg;
    logic [ROWS_W-1:0]   s4_row_reg;
    logic [HEIGHT_W-1:0] s4_ha_reg;
    logic [HEIGHT_W-1:0] s4_hb_reg;
    logic                s4_pend_a_reg;
    logic                s4_pend_b_reg;
    logic                s4_fend_reg;

    // output register
    logic                out_valid_reg;
    logic [HEIGHT_W-1:0] out_height_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROWS_W-1:0]   out_row_reg;
    logic                out_fend_reg;
    logic                out_last_reg;

    logic                in_fire;
    logic                adv;
    logic                out_free;
    logic                move;
    logic                s4_done;

    logic [ROWS_W-1:0]   rows_eff;
    logic                last_row;
    logic                interior;
    logic [NADDR_W-1:0]  cur_base;
    logic [NADDR_W-1:0]  prev_base;
    logic [NADDR_W-1:0]  wr_addr;
    logic [NADDR_W-1:0]  right_addr;

    logic [HEIGHT_W+1:0] sum4;
    logic [HEIGHT_W-1:0] diff;
    logic [HEIGHT_W-1:0] damp;
    logic [HEIGHT_W-1:0] settled;
    logic [HEIGHT_W-1:0] ha;
    logic [HEIGHT_W-1:0] hb;

    // ---------------------------------------------------------------- control

    assign out_free = !out_valid_reg || out_ready;
    assign move     = v4_reg && out_free && (s4_pend_a_reg || s4_pend_b_reg);
    assign s4_done  = v4_reg && ((!s4_pend_a_reg && !s4_pend_b_reg)
                    || (out_free && (s4_pend_a_reg ^ s4_pend_b_reg)));
    assign adv      = !v4_reg || s4_done;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        rows_eff = (frame_rows_reg < FRAME_ROWS_MIN) ? FRAME_ROWS_MIN : frame_rows_reg;
        last_row = ({1'b0, row_reg} + 11'd1) >= {1'b0, rows_eff};
        // emitted cell sits at row r-1: interior needs r-1 >= 1 and r < rows
        interior = (row_reg >= 10'd2) && (row_reg < rows_eff)
                && (col_reg != '0) && (col_reg != LAST_COL);
    end

    always_comb
    begin
        if (col_reg == LAST_COL)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 10'd1;
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_comb
    begin
        cur_base  = row_reg[0] ? BANK_OFS : '0;
        prev_base = row_reg[0] ? '0 : BANK_OFS;
        wr_addr   = cur_base + NADDR_W'(col_reg);
        // last column prefetches column 0 of this row for the next row's window
        if (col_reg == LAST_COL)
            right_addr = cur_base;
        else
            right_addr = prev_base + NADDR_W'(col_reg) + NADDR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_shift_reg <= DAMPING_SHIFT_RESET;
            frame_rows_reg    <= FRAME_ROWS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DAMPING_SHIFT: damping_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_FRAME_ROWS:    frame_rows_reg    <= cfg_data[ROWS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            s4_pend_a_reg <= 1'b0;
            s4_pend_b_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                v1_reg        <= in_fire;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                s4_pend_a_reg <= v3_reg && (s3_row_reg != '0);
                s4_pend_b_reg <= v3_reg && s3_last_row_reg;
            end
            else if (move)
            begin
                if (s4_pend_a_reg)
                    s4_pend_a_reg <= 1'b0;
                else
                    s4_pend_b_reg <= 1'b0;
            end
            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- memories

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            newer_mem[wr_addr] <= newer_height;
            older_mem[col_reg] <= {force_peak, older_height};
            rd_above_reg       <= newer_mem[wr_addr];
            rd_right_reg       <= newer_mem[right_addr];
            rd_older_reg       <= older_mem[col_reg];
        end
    end

    // ---------------------------------------------------------------- datapath

    always_comb
    begin
        sum4 = {2'b00, rd_above_reg} + {2'b00, s1_below_reg}
             + {2'b00, win_left_reg} + {2'b00, rd_right_reg};
        diff = (s2_smooth_reg > s2_held_reg[HEIGHT_W-1:0])
             ? s2_smooth_reg - s2_held_reg[HEIGHT_W-1:0] : '0;
        damp = s3_diff_reg >> damping_shift_reg;
        settled = (damp < s3_diff_reg) ? s3_diff_reg - damp : '0;
        if (s3_held_reg[HEIGHT_W])
            ha = HEIGHT_MAX;
        else if (s3_interior_reg)
            ha = settled;
        else
            ha = s3_held_reg[HEIGHT_W-1:0];
        hb = s3_cur_reg[HEIGHT_W] ? HEIGHT_MAX : s3_cur_reg[HEIGHT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_below_reg    <= newer_height;
            s1_last_row_reg <= last_row;
            s1_interior_reg <= interior;
            s1_fend_reg     <= (col_reg == LAST_COL);
            s1_cur_reg      <= {force_peak, older_height};
        end
        if (adv)
        begin
            if (v1_reg)
            begin
                win_left_reg <= win_mid_reg;
                win_mid_reg  <= rd_right_reg;
            end
            s2_col_reg      <= s1_col_reg;
            s2_row_reg      <= s1_row_reg;
            s2_smooth_reg   <= sum4[HEIGHT_W:1];
            s2_held_reg     <= rd_older_reg;
            s2_last_row_reg <= s1_last_row_reg;
            s2_interior_reg <= s1_interior_reg;
            s2_fend_reg     <= s1_fend_reg;
            s2_cur_reg      <= s1_cur_reg;

            s3_col_reg      <= s2_col_reg;
            s3_row_reg      <= s2_row_reg;
            s3_diff_reg     <= diff;
            s3_held_reg     <= s2_held_reg;
            s3_last_row_reg <= s2_last_row_reg;
            s3_interior_reg <= s2_interior_reg;
            s3_fend_reg     <= s2_fend_reg;
            s3_cur_reg      <= s2_cur_reg;

            s4_col_reg      <= s3_col_reg;
            s4_row_reg      <= s3_row_reg;
            s4_ha_reg       <= ha;
            s4_hb_reg       <= hb;
            s4_fend_reg     <= s3_fend_reg;
        end
        if (move)
        begin
            out_col_reg <= s4_col_reg;
            if (s4_pend_a_reg)
            begin
                // cell of the row above
                out_height_reg <= s4_ha_reg;
                out_row_reg    <= s4_row_reg - 10'd1;
                out_fend_reg   <= 1'b0;
                out_last_reg   <= !s4_pend_b_reg;
            end
            else
            begin
                // border cell of the last row
                out_height_reg <= s4_hb_reg;
                out_row_reg    <= s4_row_reg;
                out_fend_reg   <= s4_fend_reg;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_height  = out_height_reg;
    assign cell_column = COORD_W'(out_col_reg);
    assign cell_row    = out_row_reg;
    assign frame_end   = out_fend_reg;
    assign last_of_run = out_last_reg;

    // ---------------------------------------------------------------- checks

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= LAST_COL)
        else $error("column counter beyond row width");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (col_reg == LAST_COL) |=> (col_reg == '0))
        else $error("column counter did not wrap at end of row");

    a_port_apart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (right_addr != wr_addr))
        else $error("window read collides with line store write");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        move && s4_pend_a_reg && s4_pend_b_reg
        |=> v4_reg && s4_pend_b_reg && !s4_pend_a_reg && !out_last_reg)
        else $error("second result of a last-row item lost");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v4_reg && (s4_pend_a_reg || s4_pend_b_reg))
        else $error("input stalled with no pending result");

endmodule

@@ sim/water_ripple_stencil_step_tb.sv @@
// water_ripple_stencil_step_tb: self-checking bench for the ripple stencil step
// needs wrss_pkg and water_ripple_stencil_step; predicts every emitted cell and
// checks it field by field under random valid/ready idling and config changes

module water_ripple_stencil_step_tb;
    import wrss_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 120;
    localparam int NUM_PHASES    = 8;
    // marks a run field as random, or a result height as computed by the predictor
    localparam int RAND_VAL  = -1;
    localparam int PREDICTED = -1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic                fend;
        logic                last;
    } cell_t;

    // one run of identical cells in the directed frame
    typedef struct packed {
        int count;
        int newer;
        int older;
        int peak;
        int want_above;
        int want_here;
    } cell_run_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [HEIGHT_W-1:0]   newer_height;
    logic [HEIGHT_W-1:0]   older_height;
    logic                  force_peak;
    logic                  out_valid;
    logic                  out_ready;
    logic [HEIGHT_W-1:0]   new_height;
    logic [COORD_W-1:0]    cell_column;
    logic [COORD_W-1:0]    cell_row;
    logic                  frame_end;
    logic                  last_of_run;

    // typed heights that travel with the offered cell
    int typed_above;
    int typed_here;

    // predictor copy of the line stores, raster position and registers
    logic [HEIGHT_W-1:0] newer_rows [2][ROW_WIDTH];
    logic [HEIGHT_W:0]   older_line [ROW_WIDTH];
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    logic [SHIFT_W-1:0]  damp_shift = DAMPING_SHIFT_RESET;
    logic [ROWS_W-1:0]   rows_per_frame = FRAME_ROWS_RESET;

    cell_t     cells_due [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        hold_requests = 0;
    bit        idle_on = 1'b1;
    cell_run_t frame_plan [10];
    int        phase_rows [NUM_PHASES] = '{1023, 2, 3, 0, 1, 4, 7, 3};
    int        phase_damp [NUM_PHASES] = '{15, 1, 11, 15, 3, 1, 15, 6};

    water_ripple_stencil_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .newer_height (newer_height),
        .older_height (older_height),
        .force_peak   (force_peak),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_height   (new_height),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .frame_end    (frame_end),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [HEIGHT_W-1:0] any_height();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return HEIGHT_MAX;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // advance the raster by one cell and queue the cells it emits
    function automatic void ripple_update(input logic [HEIGHT_W-1:0] nh,
                                          input logic [HEIGHT_W-1:0] oh,
                                          input logic pk, input int wa, input int wh);
        int unsigned    rows_eff, c, r, er, sum, smooth, diff, damp;
        logic [HEIGHT_W:0] held;
        logic [HEIGHT_W-1:0] h;
        bit             last_row;
        cell_t          res;
        rows_eff = (rows_per_frame < FRAME_ROWS_MIN) ? FRAME_ROWS_MIN : rows_per_frame;
        c = col_pos;
        r = row_pos;
        last_row = (r + 1 >= rows_eff);
        if (r != 0)
        begin
            er = r - 1;
            held = older_line[c];
            if (held[HEIGHT_W])
                h = HEIGHT_MAX;
            else if (er >= 1 && er + 1 < rows_eff && c >= 1 && c + 1 < ROW_WIDTH)
            begin
                sum = 32'(newer_rows[r & 1][c]) + 32'(nh)
                    + 32'(newer_rows[(r + 1) & 1][c - 1])
                    + 32'(newer_rows[(r + 1) & 1][c + 1]);
                smooth = (sum >> 1) & 32'hffff;
                diff = (smooth > held[HEIGHT_W-1:0]) ? smooth - held[HEIGHT_W-1:0] : 0;
                damp = diff >> damp_shift;
                h = (damp < diff) ? 16'(diff - damp) : '0;
            end
            else
                h = held[HEIGHT_W-1:0];
            if (wa >= 0)
                h = wa[HEIGHT_W-1:0];
            res.height = h;
            res.col    = c[COORD_W-1:0];
            res.row    = er[COORD_W-1:0];
            res.fend   = 1'b0;
            res.last   = !last_row;
            cells_due.push_back(res);
        end
        if (last_row)
        begin
            res.height = pk ? HEIGHT_MAX : oh;
            if (wh >= 0)
                res.height = wh[HEIGHT_W-1:0];
            res.col  = c[COORD_W-1:0];
            res.row  = r[COORD_W-1:0];
            res.fend = (c + 1 == ROW_WIDTH);
            res.last = 1'b1;
            cells_due.push_back(res);
        end
        newer_rows[r & 1][c] = nh;
        older_line[c] = {pk, oh};
        if (c + 1 >= ROW_WIDTH)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((r + 1) & 32'h3ff);
        end
        else
            col_pos = c + 1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            ripple_update(newer_height, older_height, force_peak, typed_above, typed_here);
    end

    always @(posedge clk)
    begin : check_results
        cell_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (cells_due.size() == 0)
            begin
                $error("result transfer with nothing pending: col %0d row %0d",
                       cell_column, cell_row);
                mismatches++;
            end
            else
            begin
                due = cells_due.pop_front();
                if (new_height !== due.height)
                begin
                    $error("new_height: expected %h, got %h", due.height, new_height);
                    mismatches++;
                end
                if (cell_column !== due.col)
                begin
                    $error("cell_column: expected %0d, got %0d", due.col, cell_column);
                    mismatches++;
                end
                if (cell_row !== due.row)
                begin
                    $error("cell_row: expected %0d, got %0d", due.row, cell_row);
                    mismatches++;
                end
                if (frame_end !== due.fend)
                begin
                    $error("frame_end: expected %b, got %b", due.fend, frame_end);
                    mismatches++;
                end
                if (last_of_run !== due.last)
                begin
                    $error("last_of_run: expected %b, got %b", due.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // result side: short random stalls, plus a long hold when one is requested
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left = 0;
        holds_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** water_ripple_stencil_step: FAILED **");
        $finish;
    end

    // offer one cell and hold it until the transfer
    task automatic offer_cell(input logic [HEIGHT_W-1:0] nh, input logic [HEIGHT_W-1:0] oh,
                              input logic pk, input int wa, input int wh);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        newer_height <= nh;
        older_height <= oh;
        force_peak   <= pk;
        typed_above  <= wa;
        typed_here   <= wh;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // row 0 cells emit nothing, so let the pipeline empty after the last result
    task automatic drain_results();
        in_valid <= 1'b0;
        // let the predictor queue the cells of the last transfer first
        @(posedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_registers(input int damp, input int rows);
        cfg_write <= 1'b1;
        cfg_index <= REG_DAMPING_SHIFT;
        cfg_data  <= CFG_DATA_W'(damp);
        @(posedge clk);
        damp_shift = damp[SHIFT_W-1:0];
        cfg_index <= REG_FRAME_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        rows_per_frame = rows[ROWS_W-1:0];
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        cell_run_t run;
        int        i;
        int        k;
        int        p;
        logic [HEIGHT_W-1:0] nh;
        logic [HEIGHT_W-1:0] oh;
        logic      pk;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_DAMPING_SHIFT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        newer_height <= '0;
        older_height <= '0;
        force_peak   <= 1'b0;
        typed_above  <= PREDICTED;
        typed_here   <= PREDICTED;

        // one three-row frame with a zero damping shift: row 0 fills, row 1 emits the
        // border row above, the last row emits two cells per transfer
        frame_plan = '{
            '{1,   'hffff,   'hffff,   0, PREDICTED, PREDICTED},
            '{1,   0,        0,        1, PREDICTED, PREDICTED},
            '{158, RAND_VAL, 'h1234,   0, PREDICTED, PREDICTED},
            '{1,   RAND_VAL, RAND_VAL, 0, 'hffff,    PREDICTED},
            '{1,   0,        'hffff,   0, 'hffff,    PREDICTED},
            '{158, RAND_VAL, RAND_VAL, 0, 'h1234,    PREDICTED},
            // interior cells with a zero damping shift settle to zero
            '{1,   RAND_VAL, 'habcd,   0, PREDICTED, 'habcd},
            '{79,  RAND_VAL, RAND_VAL, 1, 0,         'hffff},
            '{79,  'hffff,   0,        0, 0,         0},
            '{1,   0,        'hffff,   0, PREDICTED, 'hffff}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_registers(0, 3);

        for (i = 0; i < 10; i++)
        begin
            run = frame_plan[i];
            for (k = 0; k < run.count; k++)
            begin
                nh = (run.newer == RAND_VAL) ? any_height() : run.newer[HEIGHT_W-1:0];
                oh = (run.older == RAND_VAL) ? any_height() : run.older[HEIGHT_W-1:0];
                pk = run.peak[0];
                offer_cell(nh, oh, pk, run.want_above, run.want_here);
            end
        end

        // random phases; rows 1023 followed by rows 2 shrinks the frame mid-row
        phase_damp[NUM_PHASES-1] = $urandom_range(1, 14);
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            load_registers(phase_damp[p], phase_rows[p]);
            if (p == 2)
                hold_requests++;
            k = (p == 0) ? 400 : $urandom_range(30, 70);
            repeat (k)
                offer_cell(any_height(), any_height(), ($urandom_range(0, 15) == 0),
                           PREDICTED, PREDICTED);
        end

        drain_results();
        if (mismatches == 0)
            $display("** water_ripple_stencil_step: PASSED **");
        else
            $display("** water_ripple_stencil_step: FAILED **");
        $finish;
    end

endmodule
